// ===== rtl/core/lwe_enc_pkg.sv =====
// Package: shared types, constants and helpers for the LWE encryption block.
`timescale 1ns / 1ps
`default_nettype none

package lwe_enc_pkg;

   localparam int MAX_KEY_LENGTH = 1024;
   localparam int KEY_ADDR_W     = $clog2(MAX_KEY_LENGTH);
   localparam int KEY_W          = 8;
   localparam int WORD_W         = 64;
   localparam int COUNT_W        = 11;
   localparam int MODBITS_W      = 7;
   localparam int SCALE_W        = 16;
   localparam int NOISE_W        = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Request kinds
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_MASK   = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MODULUS_BITS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNAL_SCALE = 2'd2;

   localparam logic [MODBITS_W-1:0] MODULUS_BITS_RESET = 7'd32;
   localparam logic [COUNT_W-1:0]   KEY_LENGTH_RESET   = 11'd100;
   localparam logic [SCALE_W-1:0]   SIGNAL_SCALE_RESET = 16'd1;

   typedef struct packed {
      logic [1:0]                kind;
      logic [9:0]                key_index;
      logic [KEY_W-1:0]          key_value;
      logic [WORD_W-1:0]         random_word;
      logic signed [WORD_W-1:0]  message;
      logic signed [NOISE_W-1:0] noise;
      logic                      signal_mode;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] cipher_word;
      logic              is_body;
      logic              last;
      logic              error;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [KEY_ADDR_W-1:0] addr;
      logic [KEY_W-1:0]      data;
   } key_wr_type;

   // Mask for q = 2^bits, bits clamped to 1..64
   function automatic logic [WORD_W-1:0] q_mask_f(input logic [MODBITS_W-1:0] bits);
      logic [MODBITS_W-1:0] b;
      logic [WORD_W:0]      one_hot;
      b = bits;
      if (b == '0) begin
         b = 7'd1;
      end
      if (b >= 7'(WORD_W)) begin
         return {WORD_W{1'b1}};
      end
      one_hot = (WORD_W+1)'(1) << b;
      return WORD_W'(one_hot - (WORD_W+1)'(1));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lwe_encrypt_top.sv =====
// Top level of the LWE encryption block: key store, accumulator and body stage.
//
//   channel  | ports                            | direction
//   ---------+----------------------------------+----------
//   request  | req_valid, req_stall, req_data   | in
//   result   | rsp_valid, rsp_stall, rsp_data   | out
//   config   | csr_we, csr_index, csr_wdata     | in
//
// One request per cycle while req_stall is low. A mask or finish request shows its result
// on rsp_valid from the output register: the key memory read and the stage 1 register are
// loaded at the accepting edge, and the multiply-accumulate or body sum lands in the output
// register when stage 1 advances.
// Reset is synchronous; it clears the accumulator, the mask count, the valid flags and the
// configuration registers, not the key memory. A stalled result holds the output register,
// and a request is still accepted while the middle stage is free.
`timescale 1ns / 1ps
`default_nettype none

module lwe_encrypt_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire lwe_enc_pkg::req_type                 req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output lwe_enc_pkg::rsp_type                      rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [lwe_enc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lwe_enc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lwe_enc_pkg::*;

   // configuration
   logic [MODBITS_W-1:0] modbits_ff;
   logic [COUNT_W-1:0]   keylen_ff;
   logic [SCALE_W-1:0]   scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modbits_ff <= MODULUS_BITS_RESET;
         keylen_ff  <= KEY_LENGTH_RESET;
         scale_ff   <= SIGNAL_SCALE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS_BITS: modbits_ff <= csr_wdata[MODBITS_W-1:0];
            CSR_KEY_LENGTH:   keylen_ff  <= csr_wdata[COUNT_W-1:0];
            CSR_SIGNAL_SCALE: scale_ff   <= csr_wdata[SCALE_W-1:0];
            default:          ;
         endcase
      end
   end

   logic [WORD_W-1:0] q_mask;
   assign q_mask = q_mask_f(modbits_ff);

   // handshake and stage control
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic s1_advance, s1_load, s1_move, req_accept;
   logic is_load, is_mask, is_finish;

   assign is_load    = req_data.kind == KIND_LOAD;
   assign is_mask    = req_data.kind == KIND_MASK;
   assign is_finish  = req_data.kind == KIND_FINISH;
   assign s1_advance = !out_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || s1_advance;
   assign s1_move    = s1_valid_ff && s1_advance;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;

   assign s1_valid_in  = s1_load ? (req_accept && (is_mask || is_finish)) : s1_valid_ff;
   assign out_valid_in = s1_advance ? s1_valid_ff : out_valid_ff;

   // mask count
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (req_accept && is_mask && count_ff != COUNT_MAX) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (req_accept && is_finish) begin
         count_in = '0;
      end
   end

   // key store
   key_wr_type        key_wr;
   logic [KEY_W-1:0]  key_rd;

   assign key_wr.en   = req_accept && is_load;
   assign key_wr.addr = KEY_ADDR_W'(req_data.key_index);
   assign key_wr.data = req_data.key_value;

   lwe_enc_key_store u_key_store (
      .clock   (clock),
      .wr      (key_wr),
      .rd_en   (req_accept && is_mask),
      .rd_addr (count_ff[KEY_ADDR_W-1:0]),
      .rd_data (key_rd)
   );

   // stage 1 payload: mask word or message (scaled in signal mode) share one register
   logic                      s1_body_ff, s1_body_in;
   logic [WORD_W-1:0]         s1_word_ff, s1_word_in;
   logic signed [NOISE_W-1:0] s1_noise_ff;
   logic                      s1_inrange_ff, s1_inrange_in;
   logic                      s1_error_ff, s1_error_in;
   logic [WORD_W+SCALE_W-1:0] msg_prod;

   assign msg_prod      = req_data.message * scale_ff;
   assign s1_body_in    = is_finish;
   assign s1_inrange_in = count_ff < COUNT_W'(MAX_KEY_LENGTH);
   assign s1_error_in   = count_ff != keylen_ff;

   always_comb begin
      if (is_finish) begin
         s1_word_in = req_data.signal_mode ? msg_prod[WORD_W-1:0] : req_data.message;
      end else begin
         s1_word_in = req_data.random_word & q_mask;
      end
   end

   // accumulate and form the body
   logic [WORD_W-1:0]       acc_ff, acc_in;
   logic [WORD_W+KEY_W-1:0] mac_prod;
   logic [WORD_W-1:0]       body_word;

   assign mac_prod  = s1_word_ff * key_rd;
   assign body_word = (WORD_W'(s1_noise_ff) + s1_word_ff - acc_ff) & q_mask;

   always_comb begin
      acc_in = acc_ff;
      if (s1_move) begin
         if (s1_body_ff) begin
            acc_in = '0;
         end else if (s1_inrange_ff) begin
            acc_in = acc_ff + mac_prod[WORD_W-1:0];
         end
      end
   end

   rsp_type out_in, out_ff;

   always_comb begin
      out_in.cipher_word = s1_body_ff ? body_word : s1_word_ff;
      out_in.is_body     = s1_body_ff;
      out_in.last        = s1_body_ff;
      out_in.error       = s1_body_ff && s1_error_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         acc_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && s1_load) begin
         s1_body_ff    <= s1_body_in;
         s1_word_ff    <= s1_word_in;
         s1_noise_ff   <= req_data.noise;
         s1_inrange_ff <= s1_inrange_in;
         s1_error_ff   <= s1_error_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lwe_enc_key_store.sv =====
// Secret key memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lwe_enc_key_store (
   input  wire logic                              clock,
   input  wire lwe_enc_pkg::key_wr_type           wr,
   input  wire logic                              rd_en,
   input  wire logic [lwe_enc_pkg::KEY_ADDR_W-1:0] rd_addr,
   output logic [lwe_enc_pkg::KEY_W-1:0]          rd_data
);
   import lwe_enc_pkg::*;

   logic [KEY_W-1:0] key_mem [MAX_KEY_LENGTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr.addr] <= wr.data;
      end
   end

   // hold read data until the next mask request
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= key_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
